// ----- rtl/core/rdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants, codes and types of the reversible deque.
// ----------------------------------------------------------------------------
package rdq_pkg;

	localparam int DEPTH  = 64;                  // entries in the ring buffer
	localparam int AW     = $clog2(DEPTH);       // ring address width
	localparam int CW     = $clog2(DEPTH + 1);   // fill count width
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_LIST       = 3'd4,
		MODE_REVERSE    = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	// One result handed from the controller to the output register.
	typedef struct packed {
		logic                     load;
		logic signed [WORD_W-1:0] value;
		status_t                  status;
		logic                     last;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/core/rdq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rdq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_ctrl
// Command decode, ring pointers and the read sequencer that walks the ring
// for pops and lists. Drives the entry RAM and forms each result.
// ----------------------------------------------------------------------------
module rdq_ctrl import rdq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic [2:0]               cmd_mode,
	input  logic signed [WORD_W-1:0] cmd_value,
	input  logic                     out_free,
	output res_t                     res,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic [WORD_W-1:0]        mem_wdata,
	output logic                     mem_re,
	output logic [AW-1:0]            mem_raddr,
	input  logic [WORD_W-1:0]        mem_rdata
);

	localparam int SW = AW + 1;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	state_t          state_q;
	logic [AW-1:0]   head_q, head_d;
	logic [CW-1:0]   count_q, count_d;
	logic            rev_q, rev_d;
	logic [AW-1:0]   ptr_q;
	logic [CW-1:0]   left_q;
	logic            down_q;
	logic            rd_v_s1;
	logic            rd_last_s1;

	logic            accept, empty, full, issue, consume;
	logic [SW-1:0]   tail_sum, back_sum;
	logic [AW-1:0]   tail_pos, back_pos;
	logic            imm_load;
	status_t         imm_status;
	logic            start_read, start_last, start_down;
	logic [AW-1:0]   start_addr, start_ptr;
	logic [CW-1:0]   start_left;

	assign cmd_ready = (state_q == S_IDLE) && out_free;
	assign accept    = cmd_valid && cmd_ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));

	// head + count stays below twice the depth, so one subtract wraps it.
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign back_sum = tail_sum - SW'(1);
	assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

	// The read stage holds one RAM word; a new read is issued only when that
	// word is gone or leaves in this cycle, so the RAM output never gets lost.
	assign issue   = (state_q == S_READ) && (left_q != '0) && (!rd_v_s1 || out_free);
	assign consume = rd_v_s1 && out_free;

	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		rev_d      = rev_q;
		mem_we     = 1'b0;
		mem_waddr  = tail_pos;
		mem_wdata  = cmd_value;
		imm_load   = 1'b0;
		imm_status = ST_EMPTY;
		start_read = 1'b0;
		start_addr = head_q;
		start_ptr  = head_q;
		start_left = '0;
		start_last = 1'b1;
		start_down = 1'b0;
		if (accept) begin
			case (mode_t'(cmd_mode))
				MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
					if (full) begin
						imm_load   = 1'b1;
						imm_status = ST_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + CW'(1);
						// A front push in one orientation lands at the stored front.
						if ((cmd_mode == MODE_PUSH_FRONT) != rev_q) begin
							head_d    = wrap_dec(head_q);
							mem_waddr = wrap_dec(head_q);
						end
					end
				end
				MODE_POP_FRONT, MODE_POP_BACK: begin
					if (empty) begin
						imm_load = 1'b1;
					end else begin
						start_read = 1'b1;
						count_d    = count_q - CW'(1);
						if ((cmd_mode == MODE_POP_FRONT) != rev_q) begin
							start_addr = head_q;
							head_d     = wrap_inc(head_q);
						end else begin
							start_addr = back_pos;
						end
						if (count_q == CW'(1)) begin
							head_d = '0;
						end
					end
				end
				MODE_LIST: begin
					if (empty) begin
						imm_load = 1'b1;
					end else begin
						start_read = 1'b1;
						start_left = count_q - CW'(1);
						start_last = (count_q == CW'(1));
						start_down = rev_q;
						start_addr = rev_q ? back_pos : head_q;
						start_ptr  = rev_q ? wrap_dec(back_pos) : wrap_inc(head_q);
					end
				end
				MODE_REVERSE: begin
					rev_d = !rev_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign mem_re    = start_read || issue;
	assign mem_raddr = start_read ? start_addr : ptr_q;

	assign res.load   = imm_load || consume;
	assign res.value  = consume ? mem_rdata : '0;
	assign res.status = consume ? ST_DATA : imm_status;
	assign res.last   = consume ? rd_last_s1 : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			rev_q      <= 1'b0;
			ptr_q      <= '0;
			left_q     <= '0;
			down_q     <= 1'b0;
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			if (start_read) begin
				state_q    <= S_READ;
				ptr_q      <= start_ptr;
				left_q     <= start_left;
				down_q     <= start_down;
				rd_v_s1    <= 1'b1;
				rd_last_s1 <= start_last;
			end else if (issue) begin
				ptr_q      <= down_q ? wrap_dec(ptr_q) : wrap_inc(ptr_q);
				left_q     <= left_q - CW'(1);
				rd_v_s1    <= 1'b1;
				rd_last_s1 <= (left_q == CW'(1));
			end else if (consume) begin
				rd_v_s1 <= 1'b0;
				if (left_q == '0) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/reversible_deque.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_deque
// Double-ended queue of signed 32-bit words in a ring buffer, with a
// reversible orientation.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the command, tdata the
// word to push. Results leave on m_axis: tdata the word, tuser the status
// (data, empty, or push dropped because full), tlast marks the final result
// of a request.
// Push, reverse and ignored codes give no result; a push into a full deque
// gives one status result, loaded at acceptance. A pop or list on an empty
// deque gives one status result at acceptance. A pop reads the entry RAM in
// the cycle it is accepted; its word waits in the RAM read register for a
// free output register. A list of N entries gives N results, one per cycle
// unless the receiver stalls, paced by the single RAM read port; the next
// request is taken in the cycle after the last word leaves the read stage.
// An output register separates the two sides; when the receiver stalls, the
// read sequencer holds its word and new requests wait for a free slot.
// After reset the deque is empty with normal orientation; the RAM content
// is not cleared, as only live entries are ever read.
// ----------------------------------------------------------------------------
module reversible_deque import rdq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic signed [WORD_W-1:0] s_axis_tdata,  // [31:0] value
	input  logic [2:0]               s_axis_tuser,  // [2:0] mode
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic signed [WORD_W-1:0] m_axis_tdata,  // [31:0] value_res
	output logic [1:0]               m_axis_tuser,  // [1:0] status
	output logic                     m_axis_tlast
);

	res_t                     res;
	logic                     out_free;
	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_waddr, mem_raddr;
	logic [WORD_W-1:0]        mem_wdata, mem_rdata;
	logic                     out_v_q;
	logic signed [WORD_W-1:0] out_value_q;
	status_t                  out_status_q;
	logic                     out_last_q;

	assign out_free = !out_v_q || m_axis_tready;

	rdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd_mode  (s_axis_tuser),
		.cmd_value (s_axis_tdata),
		.out_free  (out_free),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	rdq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res.load) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			out_value_q  <= res.value;
			out_status_q <= res.status;
			out_last_q   <= res.last;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
